// ===== design/ppioc_pkg.sv =====
// Package for the per-partition in-order completion block.
// Holds result kind codes and fixed field widths; no dependencies.
package ppioc_pkg;
  localparam int SeqW = 32;
  localparam int PartW = 4;
  localparam int KindW = 3;
  localparam int PendW = 17;
  localparam int CfgW = 16;
  localparam logic [CfgW-1:0] MaxPendingReset = 16'd10000;

  localparam logic [KindW-1:0] KIND_ISSUE_OK  = 3'd0;
  localparam logic [KindW-1:0] KIND_ISSUE_REJ = 3'd1;
  localparam logic [KindW-1:0] KIND_DIRECT    = 3'd2;
  localparam logic [KindW-1:0] KIND_RELEASE   = 3'd3;
  localparam logic [KindW-1:0] KIND_WIN_ERR   = 3'd4;

  typedef struct packed {
    logic load;     // latch input item, read partition state
    logic exec;     // process the latched item
    logic rel_step; // emit one release and shift the window
  } ppioc_cmd_t;

  typedef struct packed {
    logic single;   // exec finishes the item; no release run follows
    logic can_rel;  // window bit 0 done and release budget left
  } ppioc_sts_t;
endpackage

// ===== design/ppioc_ctrl.sv =====
// Controller state machine for the in-order completion block.
// Depends on ppioc_pkg for the command and status structs.
module ppioc_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  out_stall,
  input  logic                  out_busy,
  input  ppioc_pkg::ppioc_sts_t sts,
  output ppioc_pkg::ppioc_cmd_t cmd
);
  import ppioc_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_REL  = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic       out_free;

  // The output register can take a new result when empty or being drained.
  assign out_free = !out_busy || !out_stall;
  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt    = state_r;
    cmd          = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        // Execution rewrites the result fields, so a held result must leave first.
        if (out_free) begin
          cmd.exec  = 1'b1;
          state_nxt = sts.single ? S_IDLE : S_REL;
        end
      end
      S_REL: begin
        if (!sts.can_rel) begin
          state_nxt = S_IDLE;
        end else if (out_free) begin
          cmd.rel_step = 1'b1;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end
endmodule

// ===== design/ppioc_dp.sv =====
// Datapath: per-partition state, pending counter, window and output register.
// Depends on ppioc_pkg; driven by ppioc_ctrl commands.
module ppioc_dp #(
  parameter int PARTITIONS = 16,
  parameter int WINDOW = 32,
  parameter int MAX_OUT = 32
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  ppioc_pkg::ppioc_cmd_t    cmd,
  output ppioc_pkg::ppioc_sts_t    sts,
  input  logic                     in_req_type,
  input  logic [ppioc_pkg::PartW-1:0] in_partition,
  input  logic [ppioc_pkg::SeqW-1:0]  in_seq_num,
  input  logic                     in_success,
  input  logic                     in_ordered,
  input  logic                     in_has_notify,
  input  logic                     cfg_valid,
  input  logic [ppioc_pkg::CfgW-1:0] cfg_max_pending,
  input  logic                     out_stall,
  output logic                     out_valid,
  output logic [ppioc_pkg::KindW-1:0] out_kind,
  output logic [ppioc_pkg::PartW-1:0] out_partition,
  output logic [ppioc_pkg::SeqW-1:0]  out_seq,
  output logic                     out_success,
  output logic                     out_notify,
  output logic                     out_last
);
  import ppioc_pkg::*;

  localparam int PIW = (PARTITIONS > 1) ? $clog2(PARTITIONS) : 1;
  localparam int OFW = $clog2(WINDOW);
  localparam int CNW = $clog2(MAX_OUT + 1);
  localparam int NPart = 1 << PartW;

  // Folds every partition field value onto the state arrays, modulo PARTITIONS.
  function automatic logic [NPart*PIW-1:0] fold_table();
    logic [NPart*PIW-1:0] t;
    t = '0;
    for (int i = 0; i < NPart; i++) t[i*PIW +: PIW] = PIW'(i % PARTITIONS);
    return t;
  endfunction

  localparam logic [NPart*PIW-1:0] FoldTbl = fold_table();

  logic [SeqW-1:0]   issue_seq_r [PARTITIONS];
  logic [SeqW-1:0]   next_exp_r  [PARTITIONS];
  logic [WINDOW-1:0] done_r      [PARTITIONS];
  logic [WINDOW-1:0] res_r       [PARTITIONS];
  logic [WINDOW-1:0] ntf_r       [PARTITIONS];
  logic [PARTITIONS-1:0] tracked_r;
  logic [PendW-1:0]  pending_r;
  logic [CfgW-1:0]   max_pend_r;

  // Latched input item and working copy of its partition state.
  logic              rt_r, succ_r, ord_r, hn_r;
  logic [PartW-1:0]  part_r;
  logic [PIW-1:0]    pidx_r;
  logic [SeqW-1:0]   seq_r;
  logic [SeqW-1:0]   ns_r, ne_r;
  logic [WINDOW-1:0] dn_r, rs_r, nt_r;
  logic              trk_r;
  logic [CNW-1:0]    cnt_r;

  logic [PIW-1:0]    pidx_in;
  logic [SeqW-1:0]   off;
  logic              in_win;
  logic [WINDOW-1:0] bitm;
  logic              rejected;
  logic              out_set;

  assign pidx_in  = FoldTbl[in_partition*PIW +: PIW];
  assign off      = (rt_r ? seq_r : ns_r) - ne_r;
  assign in_win   = (off < SeqW'(WINDOW));
  assign bitm     = WINDOW'(1) << off[OFW-1:0];
  assign rejected = (pending_r > PendW'(max_pend_r));

  assign sts.single  = !rt_r || !ord_r || !trk_r || !in_win;
  assign sts.can_rel = dn_r[0] && (cnt_r != CNW'(MAX_OUT));

  // A result is loaded by every issue, unordered completion, window error
  // and release step.
  assign out_set = cmd.rel_step ||
                   (cmd.exec && (!rt_r || !ord_r || (trk_r && !in_win)));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tracked_r  <= '0;
      pending_r  <= '0;
      max_pend_r <= MaxPendingReset;
      out_valid  <= 1'b0;
      for (int i = 0; i < PARTITIONS; i++) begin
        issue_seq_r[i] <= '0;
        next_exp_r[i]  <= '0;
        done_r[i]      <= '0;
        res_r[i]       <= '0;
        ntf_r[i]       <= '0;
      end
    end else begin
      if (cfg_valid) max_pend_r <= cfg_max_pending;
      if (out_set) out_valid <= 1'b1;
      else if (out_valid && !out_stall) out_valid <= 1'b0;

      if (cmd.load) begin
        rt_r   <= in_req_type;
        part_r <= in_partition;
        pidx_r <= pidx_in;
        seq_r  <= in_seq_num;
        succ_r <= in_success;
        ord_r  <= in_ordered;
        hn_r   <= in_has_notify;
        ns_r   <= issue_seq_r[pidx_in];
        ne_r   <= next_exp_r[pidx_in];
        dn_r   <= done_r[pidx_in];
        rs_r   <= res_r[pidx_in];
        nt_r   <= ntf_r[pidx_in];
        trk_r  <= tracked_r[pidx_in];
        cnt_r  <= '0;
      end

      if (cmd.exec) begin
        out_partition <= part_r;
        out_last      <= 1'b1;
        out_notify    <= 1'b0;
        if (!rt_r) begin
          out_success <= 1'b0;
          if (rejected) begin
            out_kind <= KIND_ISSUE_REJ;
            out_seq  <= '0;
          end else begin
            out_kind <= KIND_ISSUE_OK;
            out_seq  <= ns_r;
            issue_seq_r[pidx_r] <= ns_r + 1'b1;
            pending_r <= pending_r + 1'b1;
            if (ord_r && hn_r) begin
              tracked_r[pidx_r] <= 1'b1;
              if (in_win) ntf_r[pidx_r] <= nt_r | bitm;
            end
          end
        end else begin
          if (pending_r != '0) pending_r <= pending_r - 1'b1;
          out_seq     <= seq_r;
          out_success <= succ_r;
          if (!ord_r) begin
            out_kind  <= KIND_DIRECT;
          end else if (trk_r && !in_win) begin
            out_kind  <= KIND_WIN_ERR;
          end else if (trk_r) begin
            dn_r <= dn_r | bitm;
            rs_r <= succ_r ? (rs_r | bitm) : (rs_r & ~bitm);
            done_r[pidx_r] <= dn_r | bitm;
            res_r[pidx_r]  <= succ_r ? (res_r[pidx_r] | bitm) : (res_r[pidx_r] & ~bitm);
          end
        end
      end

      if (cmd.rel_step) begin
        out_kind      <= KIND_RELEASE;
        out_partition <= part_r;
        out_seq       <= ne_r;
        out_success   <= rs_r[0];
        out_notify    <= nt_r[0];
        out_last      <= !dn_r[1] || (cnt_r == CNW'(MAX_OUT - 1));
        dn_r  <= dn_r >> 1;
        rs_r  <= rs_r >> 1;
        nt_r  <= nt_r >> 1;
        ne_r  <= ne_r + 1'b1;
        cnt_r <= cnt_r + 1'b1;
        done_r[pidx_r]     <= dn_r >> 1;
        res_r[pidx_r]      <= rs_r >> 1;
        ntf_r[pidx_r]      <= nt_r >> 1;
        next_exp_r[pidx_r] <= ne_r + 1'b1;
      end
    end
  end
endmodule

// ===== design/per_partition_in_order_completion.sv =====
// Top level of the per-partition in-order completion block.
// Depends on ppioc_pkg, ppioc_ctrl and ppioc_dp.
//
// Usage: an issue transaction (in_req_type 0) gets the partition's next
// sequence number, or is rejected when the pending count exceeds the
// max_pending register. A completion transaction (in_req_type 1) lowers the
// pending count; unordered ones are reported at once, ordered ones in a
// tracked partition set a window bit and release every consecutive done
// entry, one result per cycle while the receiver does not stall, at most
// MAX_OUT per transaction. out_last marks the final result of a transaction;
// some completions give none. An item first latches its partition state and
// then executes; a release run then emits one released entry per step. The
// single controller sequences one item at a time through the partition
// state registers, so a new item is taken only once the last is finished.
// Reset (synchronous, rst_n low) clears all partition state and the pending
// count and loads max_pending with 10000. When out_stall is high the result
// register holds and the controller waits while a result is held; in_stall
// stays high while an item is in progress. Configuration must be written
// through cfg_valid/cfg_ready while the block is idle, which is not enforced.
module per_partition_in_order_completion #(
  parameter int PARTITIONS = 16,
  parameter int WINDOW = 32,
  parameter int MAX_OUT = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_req_type,
  input  logic [3:0]  in_partition,
  input  logic [31:0] in_seq_num,
  input  logic        in_success,
  input  logic        in_ordered,
  input  logic        in_has_notify,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_kind,
  output logic [3:0]  out_partition,
  output logic [31:0] out_seq,
  output logic        out_success,
  output logic        out_notify,
  output logic        out_last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_max_pending
);
  import ppioc_pkg::*;

  ppioc_cmd_t cmd;
  ppioc_sts_t sts;

  // The register write is always taken; the user must write only while idle, as the block does not enforce it.
  assign cfg_ready = 1'b1;

  ppioc_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .out_stall(out_stall), .out_busy(out_valid), .sts(sts), .cmd(cmd)
  );

  ppioc_dp #(.PARTITIONS(PARTITIONS), .WINDOW(WINDOW), .MAX_OUT(MAX_OUT)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
    .in_req_type(in_req_type), .in_partition(in_partition),
    .in_seq_num(in_seq_num), .in_success(in_success),
    .in_ordered(in_ordered), .in_has_notify(in_has_notify),
    .cfg_valid(cfg_valid), .cfg_max_pending(cfg_max_pending),
    .out_stall(out_stall), .out_valid(out_valid), .out_kind(out_kind),
    .out_partition(out_partition), .out_seq(out_seq),
    .out_success(out_success), .out_notify(out_notify), .out_last(out_last)
  );
endmodule

// ===== bench/completion_checker.sv =====
// Checker for the per-partition in-order completion block: tracks partition
// state, predicts results of every accepted transaction and compares them.
// Depends on ppioc_pkg.
`timescale 1ns / 1ps
module completion_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic        in_req_type,
  input  logic [3:0]  in_partition,
  input  logic [31:0] in_seq_num,
  input  logic        in_success,
  input  logic        in_ordered,
  input  logic        in_has_notify,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [2:0]  out_kind,
  input  logic [3:0]  out_partition,
  input  logic [31:0] out_seq,
  input  logic        out_success,
  input  logic        out_notify,
  input  logic        out_last,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [15:0] cfg_max_pending,
  output int          fail_count,
  output int          pending_results
);
  import ppioc_pkg::*;

  localparam int Parts = 16;
  localparam int Win = 32;
  localparam int MaxRel = 32;

  typedef struct packed {
    logic [2:0]  kind;
    logic [3:0]  part;
    logic [31:0] seq;
    logic        succ;
    logic        ntf;
    logic        last;
  } completion_t;

  completion_t expected_q[$];

  logic [31:0] issue_seq [Parts];
  logic        tracked [Parts];
  logic [31:0] next_exp [Parts];
  logic [Win-1:0] done_w [Parts];
  logic [Win-1:0] succ_w [Parts];
  logic [Win-1:0] ntf_w [Parts];
  logic [PendW-1:0] pend_cnt;
  logic [CfgW-1:0]  max_pend;

  function automatic completion_t mk(logic [2:0] k, logic [3:0] p, logic [31:0] s,
                                     logic sc, logic n, logic l);
    completion_t r;
    r.kind = k; r.part = p; r.seq = s; r.succ = sc; r.ntf = n; r.last = l;
    return r;
  endfunction

  // Appends one predicted result at the tail of the queue.
  task automatic queue_result(completion_t r);
    expected_q = {expected_q, r};
  endtask

  // Applies one transaction to the predicted state and queues its results.
  task automatic predict_transaction(logic rt, logic [3:0] p, logic [31:0] s,
                                     logic sc, logic ord, logic nt);
    logic [31:0] off;
    int n;
    if (!rt) begin
      if (pend_cnt > max_pend) begin
        queue_result(mk(KIND_ISSUE_REJ, p, 0, 0, 0, 1));
      end else begin
        off = issue_seq[p] - next_exp[p];
        if (ord && nt) begin
          tracked[p] = 1'b1;
          if (off < Win) ntf_w[p][off[4:0]] = 1'b1;
        end
        queue_result(mk(KIND_ISSUE_OK, p, issue_seq[p], 0, 0, 1));
        issue_seq[p] = issue_seq[p] + 1;
        pend_cnt = pend_cnt + 1;
      end
    end else begin
      if (pend_cnt > 0) pend_cnt = pend_cnt - 1;
      if (!ord) begin
        queue_result(mk(KIND_DIRECT, p, s, sc, 0, 1));
      end else if (tracked[p]) begin
        off = s - next_exp[p];
        if (off >= Win) begin
          queue_result(mk(KIND_WIN_ERR, p, s, sc, 0, 1));
        end else begin
          done_w[p][off[4:0]] = 1'b1;
          succ_w[p][off[4:0]] = sc;
          n = 0;
          while (n < MaxRel && done_w[p][0]) begin
            // The run ends at the first gap or at the per-transaction limit.
            queue_result(mk(KIND_RELEASE, p, next_exp[p], succ_w[p][0],
                            ntf_w[p][0], (n == MaxRel - 1) || !done_w[p][1]));
            n++;
            done_w[p] = done_w[p] >> 1;
            succ_w[p] = succ_w[p] >> 1;
            ntf_w[p] = ntf_w[p] >> 1;
            next_exp[p] = next_exp[p] + 1;
          end
        end
      end
    end
  endtask

  always @(posedge clk) begin
    completion_t got, want;
    if (!rst_n) begin
      for (int i = 0; i < Parts; i++) begin
        issue_seq[i] = 0; tracked[i] = 0; next_exp[i] = 0;
        done_w[i] = 0; succ_w[i] = 0; ntf_w[i] = 0;
      end
      pend_cnt = 0;
      max_pend = MaxPendingReset;
      expected_q.delete();
      fail_count = 0;
    end else begin
      if (cfg_valid && cfg_ready) max_pend = cfg_max_pending;
      if (in_valid && !in_stall)
        predict_transaction(in_req_type, in_partition, in_seq_num, in_success,
                            in_ordered, in_has_notify);
      if (out_valid && !out_stall) begin
        got = mk(out_kind, out_partition, out_seq, out_success, out_notify, out_last);
        if (expected_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("unexpected result %h", got);
        end else begin
          want = expected_q.pop_front();
          if (got !== want) begin
            fail_count++;
            if (fail_count <= 10)
              $display("mismatch: expected kind %0d part %0d seq %h succ %b ntf %b last %b,",
                       want.kind, want.part, want.seq, want.succ, want.ntf, want.last,
                       " got kind %0d part %0d seq %h succ %b ntf %b last %b",
                       got.kind, got.part, got.seq, got.succ, got.ntf, got.last);
          end
        end
      end
    end
    pending_results = expected_q.size();
  end
endmodule

// ===== bench/testbench.sv =====
// Top of the bench: clock, reset, stimulus and the final verdict.
// Depends on per_partition_in_order_completion and completion_checker.
`timescale 1ns / 1ps
module testbench;
  import ppioc_pkg::*;

  // Cycles without any accepted transaction before the run is given up.
  localparam int StallLimit = 20000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_req_type = 1'b0;
  logic [3:0]  in_partition = '0;
  logic [31:0] in_seq_num = '0;
  logic        in_success = 1'b0;
  logic        in_ordered = 1'b0;
  logic        in_has_notify = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  out_kind;
  logic [3:0]  out_partition;
  logic [31:0] out_seq;
  logic        out_success;
  logic        out_notify;
  logic        out_last;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_max_pending = '0;

  int fail_count;
  int pending_results;
  int idle_cycles = 0;
  int stall_left = 0;
  bit ask_gaps = 1'b1;

  // Per-partition count of issued sequence numbers as seen by the stimulus,
  // used to aim completions at the reorder window. Rejected issues are
  // counted as well, so these can run ahead of the block.
  logic [31:0] issued [16];

  always #10 clk = ~clk;

  per_partition_in_order_completion dut (.*);

  completion_checker chk (.*);

  // Short gaps mostly, now and then a long one.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Receiver stall: random episodes, mostly short and a few long; off during
  // quiet stretches.
  always @(posedge clk) begin
    if (!ask_gaps) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 99) < 25) begin
      out_stall  <= 1'b1;
      stall_left <= gap_len();
    end else begin
      out_stall  <= 1'b0;
    end
  end

  // Watchdog on accepted transactions of any channel.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= StallLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic send(logic rt, logic [3:0] p, logic [31:0] s, logic sc,
                      logic ord, logic nt);
    int g;
    g = ask_gaps ? gap_len() : 0;
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req_type <= rt;
    in_partition <= p;
    in_seq_num <= s;
    in_success <= sc;
    in_ordered <= ord;
    in_has_notify <= nt;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (!rt) issued[p] = issued[p] + 1;
  endtask

  task automatic drain_and_write(logic [15:0] v);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
    // Untracked completions give no result; let the block finish them.
    repeat (8) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_max_pending <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int p, off, k;
    logic [31:0] base;
    for (int i = 0; i < 16; i++) issued[i] = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part. Partition 3 gets ordered issues, some with notify, then
    // completions out of order so that one completion releases a run.
    send(0, 4'd3, 32'hFFFF_FFFF, 1, 1, 1);
    send(0, 4'd3, 0, 0, 1, 0);
    send(0, 4'd3, 0, 0, 1, 1);
    send(1, 4'd3, 32'd2, 1, 1, 0);   // waits in the window
    send(1, 4'd3, 32'd1, 0, 1, 0);   // waits as well
    send(1, 4'd3, 32'd1, 1, 1, 1);   // repeat completion rewrites outcome
    send(1, 4'd3, 32'd0, 1, 1, 0);   // releases three in a row
    send(1, 4'd3, 32'd40, 0, 1, 0);  // outside the window
    send(1, 4'd3, 32'hFFFF_FFFF, 1, 1, 0); // far behind, also outside
    send(1, 4'd5, 32'd0, 1, 1, 0);   // untracked partition, no result
    send(1, 4'd15, 32'hA5A5_5A5A, 1, 0, 1); // unordered, reported directly
    send(1, 4'd0, 32'h5A5A_A5A5, 0, 0, 0);
    send(1, 4'd15, 32'd7, 0, 0, 0);  // pending count already at zero
    send(1, 4'd0, 32'd0, 0, 0, 0);
    // Issue far ahead of the window, then ordered notify past its end.
    for (k = 0; k < 34; k++) send(0, 4'd9, 0, 0, (k == 33), (k == 33));
    send(1, 4'd9, 32'd0, 1, 0, 0);

    // Rejection: max_pending 0 rejects once one item is pending.
    drain_and_write(16'd0);
    send(0, 4'd1, 0, 0, 0, 0);
    send(0, 4'd1, 0, 0, 0, 0);
    send(1, 4'd1, 0, 1, 0, 0);
    drain_and_write(16'hFFFF);
    // Long release run: 34 done entries, 32 released by one completion.
    for (k = 0; k < 34; k++) send(0, 4'd12, 0, 0, 1, 1);
    for (k = 1; k < 32; k++) send(1, 4'd12, k, k[0], 1, 0);
    send(1, 4'd12, 32'd0, 1, 1, 0);
    send(1, 4'd12, 32'd32, 1, 1, 0);
    send(1, 4'd12, 32'd33, 0, 1, 0);

    // Random part in phases with different limits.
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: drain_and_write(16'd10000);
        1: drain_and_write(16'd3);
        2: drain_and_write(16'($urandom_range(0, 65535)));
        default: drain_and_write(16'd65535);
      endcase
      ask_gaps = (ph != 1);
      for (int i = 0; i < 50; i++) begin
        p = $urandom_range(0, 15);
        k = $urandom_range(0, 99);
        if (k < 35) begin
          send(0, 4'(p), $urandom, 1'($urandom_range(0, 1)),
               $urandom_range(0, 3) != 0, 1'($urandom_range(0, 1)));
        end else if (k < 85) begin
          // Well-formed ordered completion near the partition's window.
          off = $urandom_range(0, 6);
          base = issued[p] - 1 - off;
          send(1, 4'(p), (issued[p] == 0) ? $urandom : base,
               1'($urandom_range(0, 1)), 1, 1'($urandom_range(0, 1)));
        end else begin
          send(1, 4'(p), $urandom, 1'($urandom_range(0, 1)),
               1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        end
      end
    end
    ask_gaps = 1'b1;
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (fail_count == 0 && pending_results == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end
endmodule
